// ===== design/srfb_pkg.sv =====
// shared types and constants for the sonar range filter bank
package srfb_pkg;

  localparam int DIV_HI_W  = 33;
  localparam int DIV_LO_W  = 16;
  localparam int DIV_Q_W   = 17;
  localparam int DIV_CNT_W = 5;

  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_MIN     = 3'd1;
  localparam logic [2:0] CFG_MAX     = 3'd2;
  localparam logic [2:0] CFG_EXP_A   = 3'd3;
  localparam logic [2:0] CFG_MM_A    = 3'd4;
  localparam logic [2:0] CFG_MIN_VAL = 3'd5;
  localparam logic [2:0] CFG_KAL_Q   = 3'd6;
  localparam logic [2:0] CFG_KAL_R   = 3'd7;

  localparam logic [1:0] MODE_AVG    = 2'd0;
  localparam logic [1:0] MODE_EXP    = 2'd1;
  localparam logic [1:0] MODE_MINMAX = 2'd2;
  localparam logic [1:0] MODE_KALMAN = 2'd3;

  typedef struct packed {
    logic                start;
    logic [DIV_HI_W-1:0] num_hi;
    logic [DIV_LO_W-1:0] num_lo;
    logic [DIV_HI_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/srfb_div.sv =====
// restoring divider, one quotient bit per cycle, 17-bit quotient
module srfb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  srfb_pkg::div_req_t req,
  output srfb_pkg::div_rsp_t rsp
);

  logic                                run_r;
  logic                                done_r;
  logic [srfb_pkg::DIV_CNT_W-1:0]      step_r;
  logic [srfb_pkg::DIV_HI_W:0]         rem_r;
  logic [srfb_pkg::DIV_HI_W-1:0]       den_r;
  logic [srfb_pkg::DIV_LO_W-1:0]       lo_r;
  logic [srfb_pkg::DIV_Q_W-1:0]        quo_r;
  logic                                ge;
  logic [srfb_pkg::DIV_HI_W:0]         keep;

  // the high part is below twice the divisor, so 17 steps cover the quotient
  assign ge   = rem_r >= {1'b0, den_r};
  assign keep = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (run_r) begin
        quo_r <= {quo_r[srfb_pkg::DIV_Q_W-2:0], ge};
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          rem_r  <= {keep[srfb_pkg::DIV_HI_W-1:0], lo_r[srfb_pkg::DIV_LO_W-1]};
          lo_r   <= {lo_r[srfb_pkg::DIV_LO_W-2:0], 1'b0};
          step_r <= step_r - 1'b1;
        end
      end else if (req.start) begin
        rem_r  <= {1'b0, req.num_hi};
        den_r  <= req.den;
        lo_r   <= req.num_lo;
        quo_r  <= '0;
        step_r <= srfb_pkg::DIV_CNT_W'(srfb_pkg::DIV_Q_W - 1);
        run_r  <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== design/sonar_range_filter_bank_unit.sv =====
// sonar range filter bank: per-side range filters over a shared multiplier and divider
// one word at a time; a repeated or not-upright sample goes straight to the result,
// exponential mode takes one mix, min-max two (one when out of range), kalman a divide
// plus two mixes, the moving average a ring read of one entry a cycle plus one divide
// next word is taken the cycle after a result posts; a stall only delays the next post
// synchronous active-low reset resets control, config and per-side state, not the ring
module sonar_range_filter_bank_unit #(
  parameter int RING_DEPTH = 8,
  parameter int TIMEOUT_MS = 130
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // upright, range_mm[13], time_ms[32], zero fill
  input  logic        in_tuser,   // side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // updated, filtered_distance[17], validity[16],
                                  // estimate_valid, zero fill
  output logic        out_tuser,  // out_side
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW    = $clog2(RING_DEPTH + 1);
  localparam int AW    = $clog2(2 * RING_DEPTH);
  localparam int SUM_W = 13 + FW;
  localparam int NUM_W = SUM_W + 4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_MA_WR, ST_MA_SUM, ST_MA_DIVD, ST_MA_WAITD,
    ST_KAL_DIV, ST_KAL_WAIT, ST_MIX0, ST_MIX1, ST_MIX2, ST_MIXD, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MX_EXP, MX_MMV, MX_MMD, MX_KEST, MX_KCOV
  } mix_sel_t;

  state_t   state_r;
  mix_sel_t mix_sel_r;

  // configuration
  logic [1:0]  mode_r;
  logic [12:0] min_r, max_r;
  logic [15:0] exp_a_r, mm_a_r, min_val_r;
  logic [31:0] kal_q_r, kal_r_r;

  // per-side state
  logic [IDX_W-1:0] head_r   [2];
  logic [FW-1:0]    fill_r   [2];
  logic [16:0]      exp_m_r  [2];
  logic [16:0]      mmd_r    [2];
  logic [15:0]      mmv_r    [2];
  logic [16:0]      kest_r   [2];
  logic [31:0]      kcov_r   [2];
  logic [12:0]      last_rng_r [2];
  logic [31:0]      last_tim_r [2];
  logic [16:0]      held_d_r [2];
  logic [15:0]      held_v_r [2];

  // current word
  logic        side_r, up_r, upd_r;
  logic [12:0] range_r;
  logic [31:0] time_r;

  // ring memory
  logic [13:0]   ring_mem [2*RING_DEPTH];
  logic [13:0]   rd_data_r;
  logic          rd_pend_r;
  logic [AW-1:0] base;
  logic [AW-1:0] ring_waddr, ring_raddr;
  logic          ring_we;
  logic [FW-1:0] idx_r, cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic          issue;
  logic [NUM_W-1:0] ma_num;
  logic [16:0]   ma_v;

  // shared multiplier and accumulator
  logic [31:0] mx_x_r, mx_y_r;
  logic [16:0] mx_w_r;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] prod_r;
  logic [49:0] acc_r;
  logic [33:0] mix_res;

  logic [15:0] tmp_v_r;
  logic [16:0] k_r;
  logic        ok;
  logic        is_new;
  logic [16:0] meas;
  logic [32:0] kal_den;
  logic [34:0] new_cov;

  srfb_pkg::div_req_t div_req;
  srfb_pkg::div_rsp_t div_rsp;

  srfb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic in_rng(input logic [16:0] d, input logic [12:0] lo,
                                  input logic [12:0] hi);
    in_rng = ({lo, 4'b0} <= d) && (d <= {hi, 4'b0});
  endfunction

  // fill fraction cnt * 65536 / depth, a small constant table
  function automatic logic [16:0] ma_val(input logic [FW-1:0] c);
    logic [16:0] v;
    v = '0;
    for (int i = 1; i <= RING_DEPTH; i++) begin
      if (c == FW'(i)) v = 17'((i * 65536) / RING_DEPTH);
    end
    return v;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign ok        = (range_r >= min_r) && (range_r <= max_r);
  assign meas      = {range_r, 4'b0};
  assign is_new    = (range_r != last_rng_r[side_r]) ||
                     ((time_r - last_tim_r[side_r]) >= 32'(TIMEOUT_MS));
  assign kal_den   = 33'(kcov_r[side_r]) + 33'(kal_r_r);
  assign mix_res   = acc_r[49:16];
  assign new_cov   = 35'(mix_res) + 35'(kal_q_r);

  assign base       = side_r ? AW'(RING_DEPTH) : '0;
  assign ring_waddr = base + AW'(head_r[side_r]);
  assign ring_raddr = base + AW'(idx_r[IDX_W-1:0]);
  assign ring_we    = (state_r == ST_MA_WR);
  assign issue      = (state_r == ST_MA_SUM) && (idx_r < fill_r[side_r]);
  assign ma_num     = {sum_r, 4'b0} + NUM_W'(cnt_r >> 1);
  assign ma_v       = ma_val(cnt_r);

  always_comb begin
    mul_a = (state_r == ST_MIX0) ? mx_x_r : mx_y_r;
    mul_b = (state_r == ST_MIX0) ? mx_w_r : 17'(17'd65536 - mx_w_r);
  end

  always_comb begin
    div_req = '0;
    case (state_r)
      ST_MA_DIVD: begin
        div_req.start  = (cnt_r != '0);
        div_req.num_hi = 33'(ma_num >> 16);
        div_req.num_lo = ma_num[15:0];
        div_req.den    = 33'(cnt_r);
      end
      ST_KAL_DIV: begin
        div_req.start  = (kal_den != '0);
        div_req.num_hi = 33'(kcov_r[side_r]);
        div_req.den    = kal_den;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= {ok, range_r};
    end
    rd_data_r <= ring_mem[ring_raddr];
    prod_r    <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_tvalid <= 1'b0;
      rd_pend_r  <= 1'b0;
      mode_r     <= srfb_pkg::MODE_AVG;
      min_r      <= 13'd250;
      max_r      <= 13'd2500;
      exp_a_r    <= 16'd32768;
      mm_a_r     <= 16'd32768;
      min_val_r  <= 16'd32768;
      kal_q_r    <= 32'd65536;
      kal_r_r    <= 32'd65536;
      for (int s = 0; s < 2; s++) begin
        head_r[s]     <= '0;
        fill_r[s]     <= '0;
        exp_m_r[s]    <= '0;
        mmd_r[s]      <= '0;
        mmv_r[s]      <= '0;
        kest_r[s]     <= '0;
        kcov_r[s]     <= 32'd65536;
        last_rng_r[s] <= '0;
        last_tim_r[s] <= '0;
        held_d_r[s]   <= '0;
        held_v_r[s]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          srfb_pkg::CFG_MODE:    mode_r    <= cfg_wdata[1:0];
          srfb_pkg::CFG_MIN:     min_r     <= cfg_wdata[12:0];
          srfb_pkg::CFG_MAX:     max_r     <= cfg_wdata[12:0];
          srfb_pkg::CFG_EXP_A:   exp_a_r   <= cfg_wdata[15:0];
          srfb_pkg::CFG_MM_A:    mm_a_r    <= cfg_wdata[15:0];
          srfb_pkg::CFG_MIN_VAL: min_val_r <= cfg_wdata[15:0];
          srfb_pkg::CFG_KAL_Q:   kal_q_r   <= cfg_wdata;
          srfb_pkg::CFG_KAL_R:   kal_r_r   <= cfg_wdata;
          default: ;
        endcase
      end

      // the finish state posts the next word itself
      if (out_tvalid && out_tready && (state_r != ST_FINISH)) begin
        out_tvalid <= 1'b0;
      end
      rd_pend_r <= issue;

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            side_r  <= in_tuser;
            up_r    <= in_tdata[0];
            range_r <= in_tdata[13:1];
            time_r  <= in_tdata[45:14];
            state_r <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          upd_r <= up_r && is_new;
          if (!up_r) begin
            for (int s = 0; s < 2; s++) begin
              head_r[s]  <= '0;
              fill_r[s]  <= '0;
              exp_m_r[s] <= '0;
              mmd_r[s]   <= '0;
              mmv_r[s]   <= '0;
            end
            state_r <= ST_FINISH;
          end else if (!is_new) begin
            state_r <= ST_FINISH;
          end else begin
            last_rng_r[side_r] <= range_r;
            last_tim_r[side_r] <= time_r;
            unique case (mode_r)
              srfb_pkg::MODE_AVG: state_r <= ST_MA_WR;
              srfb_pkg::MODE_EXP: begin
                mx_x_r    <= 32'(meas);
                mx_y_r    <= 32'(exp_m_r[side_r]);
                mx_w_r    <= 17'(exp_a_r);
                mix_sel_r <= MX_EXP;
                state_r   <= ST_MIX0;
              end
              srfb_pkg::MODE_MINMAX: begin
                mx_x_r    <= ok ? 32'd65536 : 32'd0;
                mx_y_r    <= 32'(mmv_r[side_r]);
                mx_w_r    <= 17'(mm_a_r);
                mix_sel_r <= MX_MMV;
                state_r   <= ST_MIX0;
              end
              default: state_r <= ST_KAL_DIV;
            endcase
          end
        end

        ST_MA_WR: begin
          head_r[side_r] <= (head_r[side_r] == IDX_W'(RING_DEPTH - 1)) ?
                            '0 : head_r[side_r] + 1'b1;
          if (fill_r[side_r] != FW'(RING_DEPTH)) begin
            fill_r[side_r] <= fill_r[side_r] + 1'b1;
          end
          idx_r   <= '0;
          sum_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_MA_SUM;
        end

        ST_MA_SUM: begin
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          if (rd_pend_r && rd_data_r[13]) begin
            sum_r <= sum_r + SUM_W'(rd_data_r[12:0]);
            cnt_r <= cnt_r + 1'b1;
          end
          if (!issue && !rd_pend_r) begin
            state_r <= ST_MA_DIVD;
          end
        end

        ST_MA_DIVD: begin
          if (cnt_r == '0) begin
            held_d_r[side_r] <= '0;
            held_v_r[side_r] <= '0;
            state_r          <= ST_FINISH;
          end else begin
            state_r <= ST_MA_WAITD;
          end
        end

        ST_MA_WAITD: begin
          if (div_rsp.done) begin
            held_d_r[side_r] <= div_rsp.quo;
            held_v_r[side_r] <= ma_v[16] ? 16'hFFFF : ma_v[15:0];
            state_r          <= ST_FINISH;
          end
        end

        ST_KAL_DIV: begin
          if (kal_den == '0) begin
            k_r       <= '0;
            mx_x_r    <= 32'(meas);
            mx_y_r    <= 32'(kest_r[side_r]);
            mx_w_r    <= '0;
            mix_sel_r <= MX_KEST;
            state_r   <= ST_MIX0;
          end else begin
            state_r <= ST_KAL_WAIT;
          end
        end

        ST_KAL_WAIT: begin
          if (div_rsp.done) begin
            k_r       <= div_rsp.quo;
            mx_x_r    <= 32'(meas);
            mx_y_r    <= 32'(kest_r[side_r]);
            mx_w_r    <= div_rsp.quo;
            mix_sel_r <= MX_KEST;
            state_r   <= ST_MIX0;
          end
        end

        ST_MIX0: state_r <= ST_MIX1;

        ST_MIX1: begin
          acc_r   <= 50'(prod_r) + 50'd32768;
          state_r <= ST_MIX2;
        end

        ST_MIX2: begin
          acc_r   <= acc_r + 50'(prod_r);
          state_r <= ST_MIXD;
        end

        ST_MIXD: begin
          unique case (mix_sel_r)
            MX_EXP: begin
              exp_m_r[side_r] <= mix_res[16:0];
              if (in_rng(mix_res[16:0], min_r, max_r)) begin
                held_d_r[side_r] <= mix_res[16:0];
                held_v_r[side_r] <= 16'hFFFF;
              end else begin
                held_d_r[side_r] <= '0;
                held_v_r[side_r] <= '0;
              end
              state_r <= ST_FINISH;
            end
            MX_MMV: begin
              // a validity of one saturates
              tmp_v_r       <= (mix_res > 34'd65535) ? 16'hFFFF : mix_res[15:0];
              mmv_r[side_r] <= (mix_res > 34'd65535) ? 16'hFFFF : mix_res[15:0];
              if (ok) begin
                mx_x_r    <= 32'(meas);
                mx_y_r    <= 32'(mmd_r[side_r]);
                mix_sel_r <= MX_MMD;
                state_r   <= ST_MIX0;
              end else begin
                held_d_r[side_r] <= '0;
                held_v_r[side_r] <= '0;
                state_r          <= ST_FINISH;
              end
            end
            MX_MMD: begin
              mmd_r[side_r]    <= mix_res[16:0];
              held_d_r[side_r] <= mix_res[16:0];
              held_v_r[side_r] <= tmp_v_r;
              state_r          <= ST_FINISH;
            end
            MX_KEST: begin
              kest_r[side_r] <= mix_res[16:0];
              // covariance update: zero new-sample term, old covariance by 1-k
              mx_x_r    <= '0;
              mx_y_r    <= kcov_r[side_r];
              mx_w_r    <= k_r;
              mix_sel_r <= MX_KCOV;
              state_r   <= ST_MIX0;
            end
            default: begin
              kcov_r[side_r] <= (new_cov > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : new_cov[31:0];
              if (in_rng(kest_r[side_r], min_r, max_r)) begin
                held_d_r[side_r] <= kest_r[side_r];
                held_v_r[side_r] <= 16'hFFFF;
              end else begin
                held_d_r[side_r] <= '0;
                held_v_r[side_r] <= '0;
              end
              state_r <= ST_FINISH;
            end
          endcase
        end

        ST_FINISH: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tuser  <= side_r;
            out_tdata  <= {5'b0,
                           up_r && (held_v_r[side_r] >= min_val_r) &&
                             in_rng(held_d_r[side_r], min_r, max_r),
                           held_v_r[side_r], held_d_r[side_r], upd_r};
            state_r    <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/sonar_range_filter_bank_unit_tb.sv =====
// self-checking testbench for the sonar range filter bank unit
module sonar_range_filter_bank_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_N  = 8;
  localparam int HOLD_MS = 130;

  typedef struct packed {
    logic        side;
    logic        upright;
    logic [12:0] range_mm;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic        side;
    logic        updated;
    logic [16:0] dist_q4;
    logic [15:0] valid_frac;
    logic        est_ok;
  } estimate_t;

  // directed row: sample plus optional typed-in expectation
  typedef struct {
    sample_t   smp;
    logic      has_exp;
    estimate_t exp_est;
  } drow_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  sonar_range_filter_bank_unit dut (.*);

  // predictor state
  logic [1:0]  p_mode;
  logic [12:0] p_min, p_max;
  logic [15:0] p_exp_a, p_mm_a, p_min_val;
  logic [31:0] p_q, p_r;
  logic [13:0] ring [2][RING_N];
  int unsigned ring_wr [2];
  int unsigned ring_cnt [2];
  logic [16:0] exp_mem [2];
  logic [16:0] mm_dist [2];
  logic [15:0] mm_val [2];
  logic [16:0] kal_est [2];
  logic [31:0] kal_cov [2];
  logic [12:0] last_rng [2];
  logic [31:0] last_t [2];
  logic [16:0] hold_dist [2];
  logic [15:0] hold_val [2];

  estimate_t expected_estimates [$];
  int        errors;
  logic      stall_enable;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit in_window(logic [63:0] d);
    return (64'(p_min) * 16 <= d) && (d <= 64'(p_max) * 16);
  endfunction

  function automatic logic [63:0] blend(logic [63:0] x, logic [63:0] y, logic [15:0] w);
    return (x * w + y * (64'd65536 - w) + 64'd32768) >> 16;
  endfunction

  function automatic void clear_soft_state();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < RING_N; i++) ring[s][i] = '0;
      ring_wr[s] = 0;
      ring_cnt[s] = 0;
      exp_mem[s] = '0;
      mm_dist[s] = '0;
      mm_val[s] = '0;
    end
  endfunction

  function automatic void reset_filter_model();
    p_mode = srfb_pkg::MODE_AVG; p_min = 250; p_max = 2500;
    p_exp_a = 16'd32768; p_mm_a = 16'd32768; p_min_val = 16'd32768;
    p_q = 32'd65536; p_r = 32'd65536;
    clear_soft_state();
    for (int s = 0; s < 2; s++) begin
      kal_est[s] = '0; kal_cov[s] = 32'd65536;
      last_rng[s] = '0; last_t[s] = '0;
      hold_dist[s] = '0; hold_val[s] = '0;
    end
  endfunction

  function automatic void run_range_filter(int s, logic [12:0] rng);
    logic        ok;
    logic [63:0] m, f, v, sum, cnt, p, den, k, np;
    ok = (rng >= p_min) && (rng <= p_max);
    m = 64'(rng) * 16;
    hold_dist[s] = '0;
    hold_val[s] = '0;
    case (p_mode)
      srfb_pkg::MODE_AVG: begin
        ring[s][ring_wr[s]] = {ok, rng};
        ring_wr[s] = (ring_wr[s] + 1) % RING_N;
        if (ring_cnt[s] < RING_N) ring_cnt[s]++;
        sum = 0; cnt = 0;
        for (int i = 0; i < ring_cnt[s]; i++)
          if (ring[s][i][13]) begin
            sum += ring[s][i][12:0];
            cnt++;
          end
        if (cnt != 0) begin
          v = (cnt * 65536) / RING_N;
          hold_dist[s] = 17'((sum * 16 + cnt / 2) / cnt);
          hold_val[s] = (v > 65535) ? 16'hFFFF : 16'(v);
        end
      end
      srfb_pkg::MODE_EXP: begin
        f = blend(m, exp_mem[s], p_exp_a);
        exp_mem[s] = 17'(f);
        if (in_window(f)) begin
          hold_dist[s] = 17'(f); hold_val[s] = 16'hFFFF;
        end
      end
      srfb_pkg::MODE_MINMAX: begin
        v = blend(ok ? 64'd65536 : 64'd0, mm_val[s], p_mm_a);
        if (v > 65535) v = 65535;
        mm_val[s] = 16'(v);
        if (ok) begin
          f = blend(m, mm_dist[s], p_mm_a);
          mm_dist[s] = 17'(f);
          hold_dist[s] = 17'(f);
          hold_val[s] = 16'(v);
        end
      end
      default: begin
        p = kal_cov[s];
        den = p + p_r;
        k = (den != 0) ? (p << 16) / den : 0;
        kal_est[s] = 17'((64'(kal_est[s]) * (65536 - k) + m * k + 32768) >> 16);
        np = ((p * (65536 - k) + 32768) >> 16) + p_q;
        kal_cov[s] = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(np);
        if (in_window(kal_est[s])) begin
          hold_dist[s] = kal_est[s]; hold_val[s] = 16'hFFFF;
        end
      end
    endcase
  endfunction

  function automatic estimate_t predict_estimate(sample_t smp);
    estimate_t e;
    int s;
    s = smp.side;
    e = '0;
    e.side = smp.side;
    if (!smp.upright) begin
      clear_soft_state();
    end else begin
      if (smp.range_mm != last_rng[s] || (smp.time_ms - last_t[s]) >= HOLD_MS) begin
        run_range_filter(s, smp.range_mm);
        last_rng[s] = smp.range_mm;
        last_t[s] = smp.time_ms;
        e.updated = 1'b1;
      end
      e.est_ok = (hold_val[s] >= p_min_val) && in_window(hold_dist[s]);
    end
    e.dist_q4 = hold_dist[s];
    e.valid_frac = hold_val[s];
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    estimate_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.side = out_tuser;
      got.updated = out_tdata[0];
      got.dist_q4 = out_tdata[17:1];
      got.valid_frac = out_tdata[33:18];
      got.est_ok = out_tdata[34];
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected word", 32'(got), 0);
      end else begin
        want = expected_estimates.pop_front();
        if (got.side != want.side) report_mismatch("side", got.side, want.side);
        if (got.updated != want.updated) report_mismatch("updated", got.updated, want.updated);
        if (got.dist_q4 != want.dist_q4) report_mismatch("distance", got.dist_q4, want.dist_q4);
        if (got.valid_frac != want.valid_frac)
          report_mismatch("validity", got.valid_frac, want.valid_frac);
        if (got.est_ok != want.est_ok) report_mismatch("estimate_valid", got.est_ok, want.est_ok);
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // receiver stalls
  initial begin
    int g;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      g = stall_enable ? pick_gap() : 0;
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end
    end
  end

  // tvalid stays up between back-to-back words and drops only before a gap
  task automatic send_sample(sample_t smp, logic has_exp, estimate_t exp_est);
    estimate_t e;
    int g;
    g = stall_enable ? pick_gap() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    e = predict_estimate(smp);
    if (has_exp && e !== exp_est) report_mismatch("typed row", 32'(exp_est), 32'(e));
    expected_estimates = {expected_estimates, e};
    in_tdata <= {2'd0, smp.time_ms, smp.range_mm, smp.upright};
    in_tuser <= smp.side;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      srfb_pkg::CFG_MODE:    p_mode = val[1:0];
      srfb_pkg::CFG_MIN:     p_min = val[12:0];
      srfb_pkg::CFG_MAX:     p_max = val[12:0];
      srfb_pkg::CFG_EXP_A:   p_exp_a = val[15:0];
      srfb_pkg::CFG_MM_A:    p_mm_a = val[15:0];
      srfb_pkg::CFG_MIN_VAL: p_min_val = val[15:0];
      srfb_pkg::CFG_KAL_Q:   p_q = val;
      srfb_pkg::CFG_KAL_R:   p_r = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic sample_t mk(logic sd, logic up, logic [12:0] r, logic [31:0] t);
    sample_t x;
    x.side = sd; x.upright = up; x.range_mm = r; x.time_ms = t;
    return x;
  endfunction

  function automatic estimate_t mk_est(logic sd, logic u, logic [16:0] d, logic [15:0] v,
                                       logic ok);
    estimate_t e;
    e.side = sd; e.updated = u; e.dist_q4 = d; e.valid_frac = v; e.est_ok = ok;
    return e;
  endfunction

  initial begin
    drow_t       rows [$];
    drow_t       row;
    sample_t     smp;
    logic [31:0] now [2];
    int          sd;
    errors = 0;
    stall_enable = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_we = 1'b0; cfg_addr = srfb_pkg::CFG_MODE; cfg_wdata = '0;
    rst_n = 1'b0;
    reset_filter_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: moving average at reset settings, repeats, timeout, extremes
    row.has_exp = 1'b1;
    row.smp = mk(0, 1, 0, 0);       row.exp_est = mk_est(0, 0, 0, 0, 0);       rows = {rows, row};
    row.smp = mk(1, 1, 1000, 5);    row.exp_est = mk_est(1, 1, 16000, 8192, 0); rows = {rows, row};
    row.smp = mk(1, 1, 1000, 134);  row.exp_est = mk_est(1, 0, 16000, 8192, 0); rows = {rows, row};
    row.smp = mk(1, 1, 1000, 135);  row.exp_est = mk_est(1, 1, 16000, 16384, 0);
    rows = {rows, row};
    row.smp = mk(0, 1, 8191, 10);   row.exp_est = mk_est(0, 1, 0, 0, 0);       rows = {rows, row};
    row.smp = mk(0, 0, 8191, 32'hFFFF_FFFF); row.exp_est = mk_est(0, 0, 0, 0, 0);
    rows = {rows, row};
    row.has_exp = 1'b0;
    row.smp = mk(1, 1, 250, 32'hFFFF_FFFF); rows = {rows, row};
    row.smp = mk(1, 1, 2500, 32'h5555_5555); rows = {rows, row};
    row.smp = mk(1, 1, 249, 32'hAAAA_AAAA); rows = {rows, row};
    row.smp = mk(1, 0, 2501, 0); rows = {rows, row};
    for (int i = 0; i < 10; i++) rows = {rows, row};
    rows = rows[0:9];
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].has_exp, rows[i].exp_est);
    wait_drained();

    // directed: exponential, min-max and kalman modes, with wrap of the timestamp
    for (int md = 1; md < 4; md++) begin
      write_reg(srfb_pkg::CFG_MODE, 32'(md));
      send_sample(mk(0, 1, 1000, 32'hFFFF_FF00), 0, '0);
      send_sample(mk(0, 1, 1000, 32'h0000_0010), 0, '0);
      send_sample(mk(0, 1, 3000, 32'h0000_0011), 0, '0);
      send_sample(mk(1, 1, 2000, 32'h0000_0012), 0, '0);
      wait_drained();
    end

    // random phases over many register settings, extremes included
    stall_enable = 1'b1;
    now[0] = $urandom; now[1] = $urandom;
    for (int ph = 0; ph < 33; ph++) begin
      write_reg(srfb_pkg::CFG_MODE, $urandom_range(0, 3));
      case (ph % 6)
        0: begin write_reg(srfb_pkg::CFG_MIN, 0); write_reg(srfb_pkg::CFG_MAX, 8191); end
        1: begin write_reg(srfb_pkg::CFG_MIN, 8191); write_reg(srfb_pkg::CFG_MAX, 0); end
        default: begin
          write_reg(srfb_pkg::CFG_MIN, $urandom_range(0, 1500));
          write_reg(srfb_pkg::CFG_MAX, $urandom_range(1500, 8191));
        end
      endcase
      write_reg(srfb_pkg::CFG_EXP_A,
                (ph % 5 == 0) ? 0 : (ph % 5 == 1) ? 16'hFFFF : $urandom);
      write_reg(srfb_pkg::CFG_MM_A,
                (ph % 5 == 2) ? 0 : (ph % 5 == 3) ? 16'hFFFF : $urandom);
      write_reg(srfb_pkg::CFG_MIN_VAL,
                (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 16'hFFFF : $urandom);
      write_reg(srfb_pkg::CFG_KAL_Q, (ph % 7 == 0) ? 0 : (ph % 7 == 1) ? 32'hFFFF_FFFF
                                                 : $urandom_range(0, 32'h0010_0000));
      write_reg(srfb_pkg::CFG_KAL_R, (ph % 7 == 2) ? 1 : (ph % 7 == 3) ? 32'hFFFF_FFFF
                                                 : $urandom_range(1, 32'h0100_0000));
      for (int n = 0; n < 50; n++) begin
        sd = $urandom_range(0, 1);
        // mostly sonar-like cadence, some repeats and random jumps
        case ($urandom_range(0, 9))
          0: now[sd] = $urandom;
          1, 2: now[sd] += $urandom_range(0, 129);
          default: now[sd] += $urandom_range(100, 160);
        endcase
        smp.side = 1'(sd);
        smp.upright = ($urandom_range(0, 24) != 0);
        smp.time_ms = now[sd];
        case ($urandom_range(0, 5))
          0: smp.range_mm = 13'($urandom);
          1: smp.range_mm = last_rng[sd];
          default: smp.range_mm = 13'($urandom_range(100, 2800));
        endcase
        send_sample(smp, 0, '0);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/srfb_pkg.sv
design/srfb_div.sv
design/sonar_range_filter_bank_unit.sv
test/sonar_range_filter_bank_unit_tb.sv
